// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bnb_pkg.sv =====
// ----------------------------------------------------------------------------
// bnb_pkg
// Shared types and constants of the bilinear nibble blitter.
// ----------------------------------------------------------------------------
package bnb_pkg;

	localparam int DIV_NW = 29;
	localparam int DIV_DW = 13;
	localparam int AW     = 28;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	localparam logic [2:0] CFG_SRC_W    = 3'd0;
	localparam logic [2:0] CFG_SRC_H    = 3'd1;
	localparam logic [2:0] CFG_DEST_X   = 3'd2;
	localparam logic [2:0] CFG_DEST_Y   = 3'd3;
	localparam logic [2:0] CFG_DEST_W   = 3'd4;
	localparam logic [2:0] CFG_DEST_H   = 3'd5;
	localparam logic [2:0] CFG_INVERTED = 3'd6;
	localparam logic [2:0] CFG_CONTRAST = 3'd7;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage

// ===== sv/bnb_ifs.sv =====
// ----------------------------------------------------------------------------
// bnb_ifs
// Valid/ready channels: pixel requests, pixel results, register writes.
// ----------------------------------------------------------------------------
interface bnb_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [16:0] load_address;
	logic [7:0]  load_data;
	logic [10:0] out_col;
	logic [10:0] out_row;

	modport source (output valid, operation, load_address, load_data, out_col, out_row,
		input ready);
	modport sink (input valid, operation, load_address, load_data, out_col, out_row,
		output ready);
endinterface

interface bnb_out_if;
	logic        valid;
	logic        ready;
	logic [17:0] fb_byte_address;
	logic        upper_nibble;
	logic [3:0]  gray_value;

	modport source (output valid, fb_byte_address, upper_nibble, gray_value, input ready);
	modport sink (input valid, fb_byte_address, upper_nibble, gray_value, output ready);
endinterface

interface bnb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bnb_div.sv =====
// ----------------------------------------------------------------------------
// bnb_div
// Restoring divider, one quotient bit per cycle; a start reloads at any time.
// ----------------------------------------------------------------------------
module bnb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bnb_pkg::div_req_t req,
	output bnb_pkg::div_rsp_t rsp
);
	import bnb_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CW'(DIV_NW);
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == CW'(1);
			if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// ===== sv/bilinear_nibble_blit_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_nibble_blit_top
// Bilinear scaler from a 4-bit packed source image to a rotated 4-bit panel.
//
//   channel  dir  payload
//   cfg      in   index, data (register write)
//   pix_in   in   operation, load_address, load_data, out_col, out_row
//   pix_out  out  fb_byte_address, upper_nibble, gray_value
//
// One item per cycle unless pix_out stalls or a refit runs.
// The source image sits in two byte banks (even/odd), two read ports each.
// After a register write the fit is recomputed, with up to three divisions in
// turn; pix_in.ready is low meanwhile.
// Reset clears the configuration registers and control; the image is undefined until loaded.
// Stages advance whenever the next one is empty or moving on.
// ----------------------------------------------------------------------------
module bilinear_nibble_blit_top #(
	parameter int SRC_BYTES = 131072,
	parameter int NATIVE_W  = 960,
	parameter int NATIVE_H  = 540
) (
	input  logic  clk,
	input  logic  arst_n,
	bnb_cfg_if.sink   cfg,
	bnb_in_if.sink    pix_in,
	bnb_out_if.source pix_out
);
	import bnb_pkg::*;

	localparam int BANK_D = (SRC_BYTES + 1) / 2;
	localparam int BW     = $clog2(BANK_D);
	localparam logic [AW-1:0]    SRC_LIM  = AW'(SRC_BYTES);
	localparam logic [AW-1:0]    SRC_LIM1 = AW'(SRC_BYTES - 1);
	localparam logic signed [13:0] NW_S   = 14'(NATIVE_W);
	localparam logic signed [13:0] NH_S   = 14'(NATIVE_H);
	localparam logic [11:0] NW_M1  = 12'(NATIVE_W - 1);
	localparam logic [11:0] NH_M1  = 12'(NATIVE_H - 1);
	localparam logic [11:0] HALF_W = 12'(NATIVE_W / 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PICK = 3'd2;
	localparam logic [2:0] ST_DIVA = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DIVX = 3'd5;
	localparam logic [2:0] ST_DIVY = 3'd6;

	// registers and derived fit
	logic [12:0] src_w_q, src_h_q;
	logic [11:0] dest_x_q, dest_y_q;
	logic [10:0] dest_w_q, dest_h_q;
	logic        inv_q;
	logic [63:0] ct_q;
	logic [2:0]  seq_q;
	logic [23:0] prod_a_q, prod_b_q;
	logic        pick_w_q;
	logic [10:0] sw_q, sh_q;
	logic [9:0]  offx_q, offy_q;
	logic [28:0] xstep_q, ystep_q;
	logic        draw_ok_q;
	logic        cfg_wr, sizes_zero, busy;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid;
	assign busy       = seq_q != ST_IDLE;
	assign sizes_zero = src_w_q == '0 || src_h_q == '0 || dest_w_q == '0 || dest_h_q == '0;

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = {src_w_q, 16'b0};
		dreq.den   = {2'b0, sw_q};
		case (seq_q)
			ST_PICK: begin
				dreq.start = !sizes_zero;
				if (prod_a_q >= prod_b_q) begin
					dreq.num = DIV_NW'(prod_b_q);
					dreq.den = src_w_q;
				end else begin
					dreq.num = DIV_NW'(prod_a_q);
					dreq.den = src_h_q;
				end
			end
			ST_CHK: begin
				dreq.start = sw_q != '0 && sh_q != '0;
			end
			ST_DIVX: begin
				dreq.start = drsp.done;
				dreq.num   = {src_h_q, 16'b0};
				dreq.den   = {2'b0, sh_q};
			end
			default: begin
			end
		endcase
	end

	bnb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= '0;
			src_h_q   <= '0;
			dest_x_q  <= '0;
			dest_y_q  <= '0;
			dest_w_q  <= '0;
			dest_h_q  <= '0;
			inv_q     <= 1'b0;
			ct_q      <= '0;
			seq_q     <= ST_IDLE;
			draw_ok_q <= 1'b0;
		end else if (cfg_wr) begin
			seq_q     <= ST_MUL;
			draw_ok_q <= 1'b0;
			case (cfg.index)
				CFG_SRC_W:    src_w_q  <= cfg.data[12:0];
				CFG_SRC_H:    src_h_q  <= cfg.data[12:0];
				CFG_DEST_X:   dest_x_q <= cfg.data[11:0];
				CFG_DEST_Y:   dest_y_q <= cfg.data[11:0];
				CFG_DEST_W:   dest_w_q <= cfg.data[10:0];
				CFG_DEST_H:   dest_h_q <= cfg.data[10:0];
				CFG_INVERTED: inv_q    <= cfg.data[0];
				CFG_CONTRAST: ct_q     <= cfg.data;
				default: begin
				end
			endcase
		end else begin
			case (seq_q)
				ST_MUL:  seq_q <= ST_PICK;
				ST_PICK: seq_q <= sizes_zero ? ST_IDLE : ST_DIVA;
				ST_DIVA: if (drsp.done) seq_q <= ST_CHK;
				ST_CHK:  seq_q <= (sw_q != '0 && sh_q != '0) ? ST_DIVX : ST_IDLE;
				ST_DIVX: if (drsp.done) seq_q <= ST_DIVY;
				ST_DIVY: begin
					if (drsp.done) begin
						seq_q     <= ST_IDLE;
						draw_ok_q <= 1'b1;
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (seq_q)
			ST_MUL: begin
				prod_a_q <= 24'(src_w_q) * 24'(dest_h_q);
				prod_b_q <= 24'(src_h_q) * 24'(dest_w_q);
			end
			ST_PICK: begin
				pick_w_q <= prod_a_q >= prod_b_q;
				if (prod_a_q >= prod_b_q)
					sw_q <= dest_w_q;
				else
					sh_q <= dest_h_q;
			end
			ST_DIVA: begin
				if (drsp.done) begin
					if (pick_w_q)
						sh_q <= drsp.quo[10:0];
					else
						sw_q <= drsp.quo[10:0];
				end
			end
			ST_DIVX: if (drsp.done) xstep_q <= drsp.quo;
			ST_DIVY: begin
				if (drsp.done) begin
					ystep_q <= drsp.quo;
					offx_q  <= 10'((dest_w_q - sw_q) >> 1);
					offy_q  <= 10'((dest_h_q - sh_q) >> 1);
				end
			end
			default: begin
			end
		endcase
	end

	// pixel pipeline
	logic v1, v2, v3, v4, v5, v6, v7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v7 || pix_out.ready;
	assign en6 = !v6 || en7;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign pix_in.ready = en1 && !busy;

	logic              acc;
	logic signed [13:0] lx_c, ly_c;
	logic              keep_c;

	assign acc  = pix_in.valid && pix_in.ready;
	assign lx_c = $signed({{2{dest_x_q[11]}}, dest_x_q}) + $signed({4'b0, offx_q})
		+ $signed({3'b0, pix_in.out_col});
	assign ly_c = $signed({{2{dest_y_q[11]}}, dest_y_q}) + $signed({4'b0, offy_q})
		+ $signed({3'b0, pix_in.out_row});
	assign keep_c = pix_in.operation == OP_LOAD
		|| (draw_ok_q && pix_in.out_col < sw_q && pix_in.out_row < sh_q
		&& !lx_c[13] && lx_c < NH_S && !ly_c[13] && ly_c < NW_S);

	// stage 1
	logic        op1, op2, op3, op4;
	logic [16:0] la1, la2, la3, la4;
	logic [7:0]  ld1, ld2, ld3, ld4;
	logic [31:0] sxq1, syq1;
	logic [11:0] lx1, ly1;

	always_ff @(posedge clk) begin
		if (en1) begin
			op1  <= pix_in.operation;
			la1  <= pix_in.load_address;
			ld1  <= pix_in.load_data;
			sxq1 <= 32'((40'(pix_in.out_col) * 40'(xstep_q)) >> 8);
			syq1 <= 32'((40'(pix_in.out_row) * 40'(ystep_q)) >> 8);
			lx1  <= lx_c[11:0];
			ly1  <= ly_c[11:0];
		end
	end

	// stage 2: clamp, corners, panel mapping
	logic [12:0] swm1, shm1, sx0_c, sy0_c;
	logic [12:0] sx0_2, sx1_2, sy0_2, sy1_2;
	logic [7:0]  fx2, fy2;
	logic [11:0] nx2, ny2;

	assign swm1  = src_w_q - 13'd1;
	assign shm1  = src_h_q - 13'd1;
	assign sx0_c = (sxq1[31:8] > {11'b0, swm1}) ? swm1 : sxq1[20:8];
	assign sy0_c = (syq1[31:8] > {11'b0, shm1}) ? shm1 : syq1[20:8];

	always_ff @(posedge clk) begin
		if (en2) begin
			op2   <= op1;
			la2   <= la1;
			ld2   <= ld1;
			sx0_2 <= sx0_c;
			sx1_2 <= (sx0_c < swm1) ? sx0_c + 13'd1 : sx0_c;
			sy0_2 <= sy0_c;
			sy1_2 <= (sy0_c < shm1) ? sy0_c + 13'd1 : sy0_c;
			fx2   <= sxq1[7:0];
			fy2   <= syq1[7:0];
			nx2   <= inv_q ? NW_M1 - ly1 : ly1;
			ny2   <= inv_q ? lx1 : NH_M1 - lx1;
		end
	end

	// stage 3: row bases
	logic [12:0] pitch;
	logic [25:0] rb0_3, rb1_3;
	logic [12:0] sx0_3, sx1_3;
	logic [7:0]  fx3, fy3;
	logic [23:0] fbrow3;
	logic [10:0] nxh3;
	logic        nxb3;

	assign pitch = 13'((14'(src_w_q) + 14'd1) >> 1);

	always_ff @(posedge clk) begin
		if (en3) begin
			op3    <= op2;
			la3    <= la2;
			ld3    <= ld2;
			rb0_3  <= 26'(sy0_2) * 26'(pitch);
			rb1_3  <= 26'(sy1_2) * 26'(pitch);
			sx0_3  <= sx0_2;
			sx1_3  <= sx1_2;
			fx3    <= fx2;
			fy3    <= fy2;
			fbrow3 <= 24'(ny2) * 24'(HALF_W);
			nxh3   <= nx2[11:1];
			nxb3   <= nx2[0];
		end
	end

	// stage 4: byte addresses
	logic [AW-1:0] a0_4, a1_4;
	logic [25:0] rb0_4, rb1_4;
	logic [12:0] sx0_4, sx1_4;
	logic [7:0]  fx4, fy4;
	logic [17:0] fb4;
	logic        nxb4, step4;

	always_ff @(posedge clk) begin
		if (en4) begin
			op4   <= op3;
			la4   <= la3;
			ld4   <= ld3;
			rb0_4 <= rb0_3;
			rb1_4 <= rb1_3;
			sx0_4 <= sx0_3;
			sx1_4 <= sx1_3;
			fx4   <= fx3;
			fy4   <= fy3;
			fb4   <= 18'(fbrow3 + 24'(nxh3));
			nxb4  <= nxb3;
		end
	end

	assign a0_4  = AW'(rb0_4) + AW'(sx0_4[12:1]);
	assign a1_4  = AW'(rb1_4) + AW'(sx0_4[12:1]);
	assign step4 = sx1_4[12:1] != sx0_4[12:1];

	// source memory, even and odd byte banks
	logic [7:0]    bank_e [BANK_D];
	logic [7:0]    bank_o [BANK_D];
	logic [AW-1:0] la_w, a0p1, a1p1;
	logic          wr;
	logic [7:0]    e0_5, e1_5, o0_5, o1_5;

	assign la_w = AW'(la4);
	assign a0p1 = a0_4 + AW'(1);
	assign a1p1 = a1_4 + AW'(1);
	assign wr   = v4 && en5 && op4 == OP_LOAD && la_w < SRC_LIM;

	always_ff @(posedge clk) begin
		if (wr && !la_w[0])
			bank_e[la_w[BW:1]] <= ld4;
		if (wr && la_w[0])
			bank_o[la_w[BW:1]] <= ld4;
		if (en5) begin
			e0_5 <= bank_e[a0p1[BW:1]];
			e1_5 <= bank_e[a1p1[BW:1]];
			o0_5 <= bank_o[a0_4[BW:1]];
			o1_5 <= bank_o[a1_4[BW:1]];
		end
	end

	// stage 5: memory data registered
	logic       p0_5, p1_5, step5, sxb0_5, sxb1_5;
	logic       ok00_5, ok10_5, ok01_5, ok11_5;
	logic [7:0] fx5, fy5;
	logic [17:0] fb5;
	logic       nxb5;

	always_ff @(posedge clk) begin
		if (en5) begin
			p0_5   <= a0_4[0];
			p1_5   <= a1_4[0];
			step5  <= step4;
			sxb0_5 <= sx0_4[0];
			sxb1_5 <= sx1_4[0];
			ok00_5 <= a0_4 < SRC_LIM;
			ok10_5 <= step4 ? a0_4 < SRC_LIM1 : a0_4 < SRC_LIM;
			ok01_5 <= a1_4 < SRC_LIM;
			ok11_5 <= step4 ? a1_4 < SRC_LIM1 : a1_4 < SRC_LIM;
			fx5    <= fx4;
			fy5    <= fy4;
			fb5    <= fb4;
			nxb5   <= nxb4;
		end
	end

	// stage 6: horizontal blend
	logic [7:0]  b00, b10, b01, b11;
	logic [3:0]  n00, n10, n01, n11;
	logic [8:0]  wfx;
	logic [11:0] top6, bot6;
	logic [7:0]  fy6;
	logic [17:0] fb6;
	logic        nxb6;

	assign b00 = p0_5 ? o0_5 : e0_5;
	assign b10 = (p0_5 ^ step5) ? o0_5 : e0_5;
	assign b01 = p1_5 ? o1_5 : e1_5;
	assign b11 = (p1_5 ^ step5) ? o1_5 : e1_5;
	assign n00 = !ok00_5 ? 4'd0 : (sxb0_5 ? b00[3:0] : b00[7:4]);
	assign n10 = !ok10_5 ? 4'd0 : (sxb1_5 ? b10[3:0] : b10[7:4]);
	assign n01 = !ok01_5 ? 4'd0 : (sxb0_5 ? b01[3:0] : b01[7:4]);
	assign n11 = !ok11_5 ? 4'd0 : (sxb1_5 ? b11[3:0] : b11[7:4]);
	assign wfx = 9'd256 - 9'(fx5);

	always_ff @(posedge clk) begin
		if (en6) begin
			top6 <= 12'(13'(n00) * 13'(wfx) + 13'(n10) * 13'(fx5));
			bot6 <= 12'(13'(n01) * 13'(wfx) + 13'(n11) * 13'(fx5));
			fy6  <= fy5;
			fb6  <= fb5;
			nxb6 <= nxb5;
		end
	end

	// stage 7: vertical blend, rounding, contrast map
	logic [20:0] vsum;
	logic [4:0]  graw;
	logic [3:0]  gsat;
	logic [17:0] fb7;
	logic        nxb7;
	logic [3:0]  gray7;

	assign vsum = 21'(12'(top6) * 21'(9'd256 - 9'(fy6))) + 21'(bot6) * 21'(fy6) + 21'd32768;
	assign graw = vsum[20:16];
	assign gsat = graw[4] ? 4'd15 : graw[3:0];

	always_ff @(posedge clk) begin
		if (en7) begin
			fb7   <= fb6;
			nxb7  <= nxb6;
			gray7 <= ct_q[{gsat, 2'b00} +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
			v7 <= 1'b0;
		end else begin
			if (en1) v1 <= acc && keep_c;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4 && op4 == OP_RENDER;
			if (en6) v6 <= v5;
			if (en7) v7 <= v6;
		end
	end

	assign pix_out.valid           = v7;
	assign pix_out.fb_byte_address = fb7;
	assign pix_out.upper_nibble    = nxb7;
	assign pix_out.gray_value      = gray7;
endmodule

// ===== sv/bnb_checker.sv =====
// ----------------------------------------------------------------------------
// bnb_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnb_checker #(
	parameter int NATIVE_W = 960,
	parameter int NATIVE_H = 540
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] fb_byte_address
);
	localparam longint FB_LIM = longint'(NATIVE_W / 2) * longint'(NATIVE_H);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_NEXT(a_cfg_lock, clk, arst_n, cfg_valid && cfg_ready, !in_ready, "taken during refit")
	`ASSERT_CLK(a_fb_range, clk, arst_n, !out_valid || longint'(fb_byte_address) < FB_LIM, "fb addr")
endmodule

bind bilinear_nibble_blit_top bnb_checker #(.NATIVE_W(NATIVE_W), .NATIVE_H(NATIVE_H)) u_bnb_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (pix_in.ready),
	.cfg_valid       (cfg.valid),
	.cfg_ready       (cfg.ready),
	.out_valid       (pix_out.valid),
	.out_ready       (pix_out.ready),
	.fb_byte_address (pix_out.fb_byte_address)
);

// ===== sim/bilinear_nibble_blit_top_test.sv =====
// ----------------------------------------------------------------------------
// bilinear_nibble_blit_top_test
// Self-checking bench for the bilinear nibble blitter: drives source loads and
// render requests under random back-pressure, predicts each framebuffer write
// and compares every transaction on the output channel with the prediction.
// ----------------------------------------------------------------------------
module bilinear_nibble_blit_top_test;
	import bnb_pkg::*;

	localparam int SRC_BYTES = 131072;
	localparam int NATIVE_W  = 960;
	localparam int NATIVE_H  = 540;
	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 16;

	typedef struct packed {
		logic [17:0] fb_addr;
		logic        upper;
		logic [3:0]  gray;
	} fb_write_t;

	typedef struct {
		bit          hit;
		fb_write_t   wr;
		longint      corner[4];
	} render_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bnb_cfg_if cfg_if ();
	bnb_in_if  in_if ();
	bnb_out_if out_if ();

	bilinear_nibble_blit_top #(
		.SRC_BYTES(SRC_BYTES), .NATIVE_W(NATIVE_W), .NATIVE_H(NATIVE_H)
	) dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_if), .pix_in(in_if), .pix_out(out_if)
	);

	always #5 clk = ~clk;

	// shadow registers and image
	logic [12:0]        src_w, src_h;
	logic signed [11:0] dst_x, dst_y;
	logic [10:0]        dst_w, dst_h;
	logic               inverted;
	logic [63:0]        contrast;
	logic [7:0]         image [SRC_BYTES];
	bit                 written [SRC_BYTES];

	fb_write_t pending_writes[$];
	int  errors = 0;
	int  cycles = 0;
	bit  quiet = 0;
	int  hold_left = 0;
	int  stall_left = 0;

	function automatic void fit_dims(output longint unsigned sw, output longint unsigned sh);
		longint unsigned w, h, dw, dh;
		w = src_w; h = src_h; dw = dst_w; dh = dst_h;
		sw = 0; sh = 0;
		if (w == 0 || h == 0 || dw == 0 || dh == 0)
			return;
		if (w * dh >= h * dw) begin
			sw = dw;
			sh = (h * dw) / w;
		end else begin
			sw = (w * dh) / h;
			sh = dh;
		end
	endfunction

	function automatic longint unsigned nibble_at(longint unsigned r, longint unsigned c,
			longint unsigned pitch, output longint where);
		longint unsigned a;
		a = r * pitch + (c >> 1);
		where = -1;
		if (a >= SRC_BYTES)
			return 0;
		where = a;
		return c[0] ? image[a][3:0] : image[a][7:4];
	endfunction

	function automatic render_t render_pixel(logic [10:0] col, logic [10:0] row);
		render_t res;
		longint unsigned sw, sh, w, h, xs, ys, sxq, syq, sx0, sx1, sy0, sy1, fx, fy, pitch;
		longint unsigned v00, v10, v01, v11, top, bot, v, g, nx, ny;
		longint lx, ly;
		res.hit = 0;
		res.wr = '0;
		for (int i = 0; i < 4; i++)
			res.corner[i] = -1;
		fit_dims(sw, sh);
		if (sw == 0 || sh == 0 || col >= sw || row >= sh)
			return res;
		lx = longint'(dst_x) + longint'((dst_w - sw) / 2) + longint'(col);
		ly = longint'(dst_y) + longint'((dst_h - sh) / 2) + longint'(row);
		if (ly < 0 || ly >= NATIVE_W || lx < 0 || lx >= NATIVE_H)
			return res;
		w = src_w; h = src_h;
		xs = (w << 16) / sw;
		ys = (h << 16) / sh;
		sxq = col * xs;
		syq = row * ys;
		sx0 = sxq >> 16;
		if (sx0 > w - 1) sx0 = w - 1;
		sx1 = (sx0 < w - 1) ? sx0 + 1 : sx0;
		fx = (sxq >> 8) & 8'hFF;
		sy0 = syq >> 16;
		if (sy0 > h - 1) sy0 = h - 1;
		sy1 = (sy0 < h - 1) ? sy0 + 1 : sy0;
		fy = (syq >> 8) & 8'hFF;
		pitch = (w + 1) / 2;
		v00 = nibble_at(sy0, sx0, pitch, res.corner[0]);
		v10 = nibble_at(sy0, sx1, pitch, res.corner[1]);
		v01 = nibble_at(sy1, sx0, pitch, res.corner[2]);
		v11 = nibble_at(sy1, sx1, pitch, res.corner[3]);
		top = v00 * (256 - fx) + v10 * fx;
		bot = v01 * (256 - fx) + v11 * fx;
		v = top * (256 - fy) + bot * fy;
		g = (v + 32768) >> 16;
		if (g > 15) g = 15;
		if (inverted) begin
			nx = NATIVE_W - 1 - ly;
			ny = lx;
		end else begin
			nx = ly;
			ny = NATIVE_H - 1 - lx;
		end
		res.hit = 1;
		res.wr.fb_addr = ny * (NATIVE_W / 2) + (nx >> 1);
		res.wr.upper = nx[0];
		res.wr.gray = contrast[4 * g +: 4];
		return res;
	endfunction

	// ---------------- output channel: back-pressure and checking -------------
	always @(posedge clk) begin
		fb_write_t got, want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = '{out_if.fb_byte_address, out_if.upper_nibble, out_if.gray_value};
			if (pending_writes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction: addr %0d upper %0b gray %0d",
						got.fb_addr, got.upper, got.gray);
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp addr %0d upper %0b gray %0d, got addr %0d upper %0b gray %0d",
							want.fb_addr, want.upper, want.gray,
							got.fb_addr, got.upper, got.gray);
				end
			end
		end
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_if.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("bilinear_nibble_blit_top test failed");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic send_item(logic op, logic [16:0] addr, logic [7:0] data,
			logic [10:0] col, logic [10:0] row);
		int gap;
		render_t r;
		gap = 0;
		if (!quiet && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.operation <= op;
		in_if.load_address <= addr;
		in_if.load_data <= data;
		in_if.out_col <= col;
		in_if.out_row <= row;
		do @(posedge clk); while (!in_if.ready);
		if (op == OP_LOAD) begin
			if (addr < SRC_BYTES) begin
				image[addr] = data;
				written[addr] = 1;
			end
		end else begin
			r = render_pixel(col, row);
			if (r.hit)
				pending_writes.push_back(r.wr);
		end
	endtask

	task automatic load_byte(logic [16:0] addr, logic [7:0] data);
		send_item(OP_LOAD, addr, data, 11'($urandom), 11'($urandom));
	endtask

	// fills any unwritten source byte the pixel would sample, then renders it
	task automatic render(logic [10:0] col, logic [10:0] row);
		render_t r;
		r = render_pixel(col, row);
		for (int i = 0; i < 4; i++)
			if (r.corner[i] >= 0 && !written[r.corner[i]])
				load_byte(17'(r.corner[i]), 8'($urandom));
		send_item(OP_RENDER, 17'($urandom), 8'($urandom), col, row);
	endtask

	task automatic drain;
		in_if.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_SRC_W:    src_w = data[12:0];
			CFG_SRC_H:    src_h = data[12:0];
			CFG_DEST_X:   dst_x = data[11:0];
			CFG_DEST_Y:   dst_y = data[11:0];
			CFG_DEST_W:   dst_w = data[10:0];
			CFG_DEST_H:   dst_h = data[10:0];
			CFG_INVERTED: inverted = data[0];
			CFG_CONTRAST: contrast = data;
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int sw, int sh, int dx, int dy, int dw, int dh, bit inv,
			logic [63:0] tab);
		drain();
		cfg_write(CFG_SRC_W, 64'(sw));
		cfg_write(CFG_SRC_H, 64'(sh));
		cfg_write(CFG_DEST_X, 64'(dx));
		cfg_write(CFG_DEST_Y, 64'(dy));
		cfg_write(CFG_DEST_W, 64'(dw));
		cfg_write(CFG_DEST_H, 64'(dh));
		cfg_write(CFG_INVERTED, 64'(inv));
		cfg_write(CFG_CONTRAST, tab);
	endtask

	task automatic random_render;
		longint unsigned sw, sh;
		fit_dims(sw, sh);
		if ($urandom_range(0, 9) == 0 || sw == 0 || sh == 0)
			render(11'($urandom), 11'($urandom));
		else
			render(11'($urandom_range(0, sw)), 11'($urandom_range(0, sh)));
	endtask

	// ---------------- tests ----------------
	task automatic test_reset_state;
		render(11'd0, 11'd0);
		render(11'd5, 11'd3);
		drain();
	endtask

	task automatic test_directed;
		configure(5, 3, 0, 0, 10, 6, 0, 64'hFEDC_BA98_7654_3210);
		for (int a = 0; a < 9; a++)
			load_byte(17'(a), (a == 0) ? 8'hFF : 8'($urandom));
		load_byte(17'd131071, 8'hFF);
		load_byte(17'd131071, 8'h00);
		render(11'd0, 11'd0);
		render(11'd9, 11'd5);
		render(11'd10, 11'd0);
		render(11'd0, 11'd6);
		render(11'd2047, 11'd2047);
		render(11'd4, 11'd2);
		configure(5, 3, 530, 955, 10, 6, 1, 64'hFFFF_FFFF_FFFF_FFFF);
		render(11'd9, 11'd4);
		render(11'd0, 11'd0);
		render(11'd9, 11'd5);
		configure(5, 3, -2048, 2047, 10, 6, 0, 64'h0);
		render(11'd1, 11'd1);
		configure(0, 3, 0, 0, 10, 6, 0, 64'hFEDC_BA98_7654_3210);
		render(11'd1, 11'd1);
		configure(5, 3, 0, 0, 0, 6, 0, 64'hFEDC_BA98_7654_3210);
		render(11'd0, 11'd0);
		configure(4096, 1, 0, 0, 3, 2047, 0, 64'h0123_4567_89AB_CDEF);
		render(11'd1, 11'd0);
		configure(4096, 4096, 10, 10, 100, 100, 1, 64'hFEDC_BA98_7654_3210);
		render(11'd50, 11'd99);
		render(11'd99, 11'd99);
		drain();
	endtask

	task automatic test_backpressure;
		configure(8, 8, 100, 200, 40, 40, 0, 64'hFEDC_BA98_7654_3210);
		hold_left = 300;
		for (int i = 0; i < 60; i++)
			render(11'(i % 40), 11'(i / 2));
		drain();
	endtask

	task automatic test_random;
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: configure($urandom_range(1, 40), $urandom_range(1, 40),
					$urandom_range(0, 600) - 20, $urandom_range(0, 1000) - 20,
					$urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(0, 1),
					{$urandom, $urandom});
				1: configure($urandom_range(1, 8191), $urandom_range(1, 8191),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 1),
					{$urandom, $urandom});
				2: configure($urandom_range(1, 300), $urandom_range(1, 300),
					$urandom_range(0, 540), $urandom_range(0, 960),
					$urandom_range(1, 200), $urandom_range(1, 200), $urandom_range(0, 1),
					{$urandom, $urandom});
				default: configure($urandom_range(1, 16), $urandom_range(1, 16),
					$urandom_range(0, 500), $urandom_range(0, 900), $urandom_range(1, 2047),
					$urandom_range(1, 30), $urandom_range(0, 1), {$urandom, $urandom});
			endcase
			for (int i = 0; i < 85; i++) begin
				if ($urandom_range(0, 9) == 0)
					load_byte(17'($urandom), 8'($urandom));
				else
					random_render();
			end
		end
		drain();
	endtask

	task automatic test_tail;
		configure(20, 12, 200, 300, 50, 50, 1, {$urandom, $urandom});
		quiet = 1;
		for (int i = 0; i < 60; i++)
			random_render();
		drain();
	endtask

	initial begin
		in_if.valid = 1'b0;
		in_if.operation = OP_LOAD;
		in_if.load_address = '0;
		in_if.load_data = '0;
		in_if.out_col = '0;
		in_if.out_row = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_SRC_W;
		cfg_if.data = '0;
		out_if.ready = 1'b0;
		src_w = '0; src_h = '0; dst_x = '0; dst_y = '0;
		dst_w = '0; dst_h = '0; inverted = 1'b0; contrast = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_backpressure();
		test_random();
		test_tail();
		if (errors == 0)
			$display("bilinear_nibble_blit_top test passed");
		else
			$display("bilinear_nibble_blit_top test failed");
		$finish;
	end
endmodule
